>>> rtl/ssi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_pkg
// Shared constants, codes and types of the sorted secondary index.
// ----------------------------------------------------------------------------
package ssi_pkg;

  localparam int DEF_DEPTH    = 64;
  localparam int DEF_KEY_BITS = 64;

  localparam int OP_W     = 2;
  localparam int KEY_IN_W = 64;
  localparam int ADDR_W   = 32;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 7;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;

  // shift commands broadcast to every cell of the chain
  typedef struct packed {
    logic ins;
    logic del;
  } cell_cmd_t;

endpackage
`default_nettype wire

>>> rtl/sorted_secondary_index.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_secondary_index
// Key/record-address table kept sorted in a chain of cells; insert, search
// with streamed matches, and delete by key and address.
//
//   channel  dir  tdata                                   tuser       tlast
//   in_      in   key[63:0], record_address[95:64]        opcode      -
//   out_     out  record_address_res[31:0],               status      last
//                 entry_count[38:32]
//
// steps: insert and unused opcodes go through S_EXEC, delete through S_EXEC and
// S_DEL whether or not the pair is there, search through S_EXEC and S_SRCH.
// the whole chain compares and shifts at once; search results leave one a cycle
// from a registered match mask while out_ is free. reset clears state, fill count
// and output valid only, no clearing pass. a stalled out_ holds the result step.
// ----------------------------------------------------------------------------
module sorted_secondary_index #(
  parameter int DEPTH    = ssi_pkg::DEF_DEPTH,
  parameter int KEY_BITS = ssi_pkg::DEF_KEY_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [95:0] in_tdata,   // key[63:0], record_address[95:64]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // record_address_res[31:0], entry_count[38:32]
  output logic [1:0]       out_tuser,  // status[1:0]
  output logic             out_tlast
);
  import ssi_pkg::*;

  localparam int LOG_D = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_SRCH = 4'b0100,
    S_DEL  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  logic [OP_W-1:0]     op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [DEPTH-1:0]    mask_r, mask_nxt;

  logic              ov_r, ov_nxt;
  logic [STAT_W-1:0] ostat_r, ostat_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic              olast_r, olast_nxt;
  logic [CNT_W-1:0]  ocnt_r, ocnt_nxt;

  logic [DEPTH-1:0]    gt_v, eq_v, dm_v, pre_v, sel_v, rest_v;
  logic [KEY_BITS-1:0] ckey [DEPTH];
  logic [ADDR_W-1:0]   caddr [DEPTH];
  logic [ADDR_W-1:0]   sel_addr;
  cell_cmd_t           cmd;
  logic                out_free, in_acc, full;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_free   = !ov_r || out_tready;
  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign out_tvalid = ov_r;
  assign out_tuser  = ostat_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {1'b0, ocnt_r, oaddr_r};

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic                left_gt;
      logic [KEY_BITS-1:0] left_key, right_key;
      logic [ADDR_W-1:0]   left_addr, right_addr;
      if (gi == 0) begin : g_first
        assign left_gt   = 1'b0;
        assign left_key  = key_r;
        assign left_addr = addr_r;
      end else begin : g_mid
        assign left_gt   = gt_v[gi-1];
        assign left_key  = ckey[gi-1];
        assign left_addr = caddr[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_key  = ckey[gi];
        assign right_addr = caddr[gi];
      end else begin : g_inner
        assign right_key  = ckey[gi+1];
        assign right_addr = caddr[gi+1];
      end
      ssi_cell #(
        .KEY_BITS (KEY_BITS),
        .IDX      (gi)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .cnt        (cnt_r),
        .new_key    (key_r),
        .new_addr   (addr_r),
        .left_gt    (left_gt),
        .left_key   (left_key),
        .left_addr  (left_addr),
        .del_shift  (pre_v[gi]),
        .right_key  (right_key),
        .right_addr (right_addr),
        .gt         (gt_v[gi]),
        .eq         (eq_v[gi]),
        .dmatch     (dm_v[gi]),
        .key_o      (ckey[gi]),
        .addr_o     (caddr[gi])
      );
    end
  endgenerate

  // cells at and after the first delete match take their right neighbor
  always_comb begin
    pre_v = mask_r;
    for (int s = 0; s < LOG_D; s++) begin
      pre_v = pre_v | (pre_v << (1 << s));
    end
  end

  // lowest pending search match and its address
  assign sel_v  = mask_r & (~mask_r + DEPTH'(1));
  assign rest_v = mask_r & ~sel_v;
  always_comb begin
    sel_addr = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_addr = sel_addr | (caddr[i] & {ADDR_W{sel_v[i]}});
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    addr_nxt  = addr_r;
    cnt_nxt   = cnt_r;
    mask_nxt  = mask_r;
    ov_nxt    = ov_r && !out_tready;
    ostat_nxt = ostat_r;
    oaddr_nxt = oaddr_r;
    olast_nxt = olast_r;
    ocnt_nxt  = ocnt_r;
    cmd       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt    = in_tuser;
          key_nxt   = in_tdata[KEY_BITS-1:0];
          addr_nxt  = in_tdata[KEY_IN_W +: ADDR_W];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (op_r == OP_SEARCH) begin
          mask_nxt  = eq_v;
          state_nxt = S_SRCH;
        end else if (op_r == OP_DELETE) begin
          mask_nxt  = dm_v & ~(dm_v - DEPTH'(1));
          state_nxt = S_DEL;
        end else if (out_free) begin
          ov_nxt    = 1'b1;
          oaddr_nxt = '0;
          olast_nxt = 1'b1;
          ocnt_nxt  = cnt_r;
          state_nxt = S_IDLE;
          if (op_r == OP_INSERT) begin
            if (full) begin
              ostat_nxt = ST_FULL;
            end else begin
              cmd.ins   = 1'b1;
              cnt_nxt   = cnt_r + CNT_W'(1);
              ocnt_nxt  = cnt_r + CNT_W'(1);
              ostat_nxt = ST_OK;
            end
          end else begin
            ostat_nxt = ST_NOTFOUND;
          end
        end
      end
      S_SRCH: begin
        if (out_free) begin
          ov_nxt   = 1'b1;
          ocnt_nxt = cnt_r;
          if (mask_r == '0) begin
            ostat_nxt = ST_NOTFOUND;
            oaddr_nxt = '0;
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            ostat_nxt = ST_OK;
            oaddr_nxt = sel_addr;
            olast_nxt = (rest_v == '0);
            mask_nxt  = rest_v;
            if (rest_v == '0) begin
              state_nxt = S_IDLE;
            end
          end
        end
      end
      S_DEL: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          oaddr_nxt = '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
          if (mask_r != '0) begin
            cmd.del   = 1'b1;
            cnt_nxt   = cnt_r - CNT_W'(1);
            ocnt_nxt  = cnt_r - CNT_W'(1);
            ostat_nxt = ST_OK;
          end else begin
            ocnt_nxt  = cnt_r;
            ostat_nxt = ST_NOTFOUND;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    key_r   <= key_nxt;
    addr_r  <= addr_nxt;
    mask_r  <= mask_nxt;
    ostat_r <= ostat_nxt;
    oaddr_r <= oaddr_nxt;
    olast_r <= olast_nxt;
    ocnt_r  <= ocnt_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/ssi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ssi_cell
// One slot of the sorted chain: holds a key/address pair, compares it with
// the pending key and takes the new pair or a neighbor's pair on a shift.
// ----------------------------------------------------------------------------
module ssi_cell #(
  parameter int KEY_BITS = 64,
  parameter int IDX      = 0
) (
  input  wire logic                       clk,
  input  wire ssi_pkg::cell_cmd_t         cmd,
  input  wire logic [ssi_pkg::CNT_W-1:0]  cnt,
  input  wire logic [KEY_BITS-1:0]        new_key,
  input  wire logic [ssi_pkg::ADDR_W-1:0] new_addr,
  input  wire logic                       left_gt,
  input  wire logic [KEY_BITS-1:0]        left_key,
  input  wire logic [ssi_pkg::ADDR_W-1:0] left_addr,
  input  wire logic                       del_shift,
  input  wire logic [KEY_BITS-1:0]        right_key,
  input  wire logic [ssi_pkg::ADDR_W-1:0] right_addr,
  output logic                            gt,
  output logic                            eq,
  output logic                            dmatch,
  output logic [KEY_BITS-1:0]             key_o,
  output logic [ssi_pkg::ADDR_W-1:0]      addr_o
);
  import ssi_pkg::*;

  logic                occ;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;

  assign occ    = cnt > CNT_W'(IDX);
  // gt marks the insert point and everything after it
  assign gt     = !(occ && (key_r <= new_key));
  assign eq     = occ && (key_r == new_key);
  assign dmatch = eq && (addr_r == new_addr);
  assign key_o  = key_r;
  assign addr_o = addr_r;

  always_comb begin
    key_nxt  = key_r;
    addr_nxt = addr_r;
    if (cmd.ins && gt) begin
      if (left_gt) begin
        key_nxt  = left_key;
        addr_nxt = left_addr;
      end else begin
        key_nxt  = new_key;
        addr_nxt = new_addr;
      end
    end else if (cmd.del && del_shift) begin
      key_nxt  = right_key;
      addr_nxt = right_addr;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    addr_r <= addr_nxt;
  end

endmodule
`default_nettype wire

>>> tb/sv/index_checker.sv
// ----------------------------------------------------------------------------
// index_checker
// Watches both streams of the sorted secondary index, keeps its own sorted
// key/address table, works out the results of every accepted command word and
// compares each returned word with the oldest one still due.
// ----------------------------------------------------------------------------
module index_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  input  wire logic        in_tready,
  input  wire logic [95:0] in_tdata,   // key[63:0], record_address[95:64]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [39:0] out_tdata,  // record_address_res[31:0], entry_count[38:32]
  input  wire logic [1:0]  out_tuser,  // status[1:0]
  input  wire logic        out_tlast,
  output int               mismatches,
  output int               pending
);
  import ssi_pkg::*;

  localparam int DEPTH = DEF_DEPTH;
  localparam logic [KEY_IN_W-1:0] KEY_MASK =
    (DEF_KEY_BITS >= KEY_IN_W) ? {KEY_IN_W{1'b1}} : ((64'd1 << DEF_KEY_BITS) - 64'd1);

  typedef struct {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic [CNT_W-1:0]  count;
  } index_result_t;

  logic [KEY_IN_W-1:0] tab_key  [DEPTH];
  logic [ADDR_W-1:0]   tab_addr [DEPTH];
  int                  tab_used;
  index_result_t       due_results [$];
  int                  errs;

  function automatic void post_result(input logic [STAT_W-1:0] status,
                                      input logic [ADDR_W-1:0] addr, input logic last);
    index_result_t r;
    r.status = status;
    r.addr   = addr;
    r.last   = last;
    r.count  = tab_used[CNT_W-1:0];
    due_results.push_back(r);
  endfunction

  function automatic void apply_index_op(input logic [OP_W-1:0] op,
                                         input logic [KEY_IN_W-1:0] key_in,
                                         input logic [ADDR_W-1:0] addr);
    logic [KEY_IN_W-1:0] key;
    int                  pos;
    int                  hits;
    int                  seen;
    key = key_in & KEY_MASK;
    case (op)
      OP_INSERT: begin
        if (tab_used >= DEPTH) begin
          post_result(ST_FULL, '0, 1'b1);
        end else begin
          pos = 0;
          // equal keys go behind the ones already there
          while (pos < tab_used && tab_key[pos] <= key) pos++;
          for (int i = tab_used; i > pos; i--) begin
            tab_key[i]  = tab_key[i-1];
            tab_addr[i] = tab_addr[i-1];
          end
          tab_key[pos]  = key;
          tab_addr[pos] = addr;
          tab_used++;
          post_result(ST_OK, '0, 1'b1);
        end
      end
      OP_SEARCH: begin
        hits = 0;
        for (int i = 0; i < tab_used; i++) if (tab_key[i] == key) hits++;
        if (hits == 0) begin
          post_result(ST_NOTFOUND, '0, 1'b1);
        end else begin
          seen = 0;
          for (int i = 0; i < tab_used; i++) begin
            if (tab_key[i] == key) begin
              seen++;
              post_result(ST_OK, tab_addr[i], seen == hits);
            end
          end
        end
      end
      OP_DELETE: begin
        pos = -1;
        for (int i = 0; i < tab_used; i++) begin
          if (pos < 0 && tab_key[i] == key && tab_addr[i] == addr) pos = i;
        end
        if (pos < 0) begin
          post_result(ST_NOTFOUND, '0, 1'b1);
        end else begin
          for (int j = pos; j + 1 < tab_used; j++) begin
            tab_key[j]  = tab_key[j+1];
            tab_addr[j] = tab_addr[j+1];
          end
          tab_used--;
          post_result(ST_OK, '0, 1'b1);
        end
      end
      default: post_result(ST_NOTFOUND, '0, 1'b1);
    endcase
  endfunction

  task automatic check_result();
    index_result_t r;
    if (due_results.size() == 0) begin
      $error("result word with nothing due: status %0d addr %0h count %0d",
             out_tuser, out_tdata[31:0], out_tdata[38:32]);
      errs++;
    end else begin
      r = due_results.pop_front();
      if (out_tuser !== r.status) begin
        $error("status: expected %0d, got %0d", r.status, out_tuser);
        errs++;
      end
      if (out_tdata[31:0] !== r.addr) begin
        $error("record_address_res: expected %0h, got %0h", r.addr, out_tdata[31:0]);
        errs++;
      end
      if (out_tlast !== r.last) begin
        $error("last: expected %0d, got %0d", r.last, out_tlast);
        errs++;
      end
      if (out_tdata[38:32] !== r.count) begin
        $error("entry_count: expected %0d, got %0d", r.count, out_tdata[38:32]);
        errs++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      tab_used = 0;
      due_results.delete();
    end else begin
      // a result word never belongs to a command taken at the same edge
      if (out_tvalid && out_tready) check_result();
      if (in_tvalid && in_tready) apply_index_op(in_tuser, in_tdata[63:0], in_tdata[95:64]);
    end
    mismatches <= errs;
    pending    <= due_results.size();
  end

endmodule

>>> tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the sorted secondary index: a directed opening on
// duplicates, extremes and misses, then insert-heavy, mixed and delete-heavy
// random traffic with bursty gaps on both streams and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import ssi_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 300;
  localparam logic [63:0] KEY_ABCD = 64'h4142_4344_0000_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;  // key[63:0], record_address[95:64]
  logic [1:0]  in_tuser = '0;  // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // record_address_res[31:0], entry_count[38:32]
  logic [1:0]  out_tuser;      // status[1:0]
  logic        out_tlast;

  int          mismatches;
  int          pending;
  bit          calm = 1'b0;
  bit          hold_armed = 1'b0;
  logic [63:0] key_pool [6];
  logic [31:0] addr_pool [4];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sorted_secondary_index uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  index_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .mismatches(mismatches), .pending(pending)
  );

  task automatic send_word(input logic [OP_W-1:0] op, input logic [63:0] key,
                           input logic [31:0] addr);
    if (!calm && $urandom_range(0, 99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {addr, key};
    do @(posedge clk); while (!in_tready);
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 99) < 80) return key_pool[$urandom_range(0, 5)];
    return {$urandom, $urandom};
  endfunction

  function automatic logic [31:0] pick_addr();
    if ($urandom_range(0, 99) < 80) return addr_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  task automatic run_traffic(input int words, input int w_ins, input int w_find,
                             input int w_del);
    int               r;
    logic [OP_W-1:0]  op;
    for (int n = 0; n < words; n++) begin
      r = $urandom_range(0, 99);
      if (r < w_ins) op = OP_INSERT;
      else if (r < w_ins + w_find) op = OP_SEARCH;
      else if (r < w_ins + w_find + w_del) op = OP_DELETE;
      else op = OP_UNUSED;
      send_word(op, pick_key(), pick_addr());
    end
  endtask

  // output side: random stalls, plus one long hold while the table fills
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (calm) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else if (hold_armed) begin
        out_tready <= 1'b0;
        hold_armed = 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < 25) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = {$urandom, $urandom};
    key_pool[3] = key_pool[2] + 64'd1;
    key_pool[4] = KEY_ABCD;
    key_pool[5] = {$urandom, $urandom};
    addr_pool[0] = '0;
    addr_pool[1] = '1;
    addr_pool[2] = $urandom;
    addr_pool[3] = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table: misses and the unused opcode
    send_word(OP_SEARCH, '0, '0);
    send_word(OP_DELETE, '0, '0);
    send_word(OP_UNUSED, '0, '0);
    // extremes and duplicate keys
    send_word(OP_INSERT, '1, '1);
    send_word(OP_INSERT, '0, '0);
    send_word(OP_INSERT, '0, 32'd5);
    send_word(OP_INSERT, '0, '1);
    send_word(OP_INSERT, KEY_ABCD, 32'h100);
    send_word(OP_SEARCH, '0, $urandom);
    send_word(OP_SEARCH, '1, $urandom);
    send_word(OP_SEARCH, KEY_ABCD, '1);
    // delete from the middle of a run of equal keys
    send_word(OP_DELETE, '0, 32'd5);
    send_word(OP_SEARCH, '0, '0);
    send_word(OP_DELETE, '0, 32'd7);
    send_word(OP_DELETE, '1, '1);
    send_word(OP_UNUSED, {$urandom, $urandom}, $urandom);
    send_word(OP_SEARCH, '1, '0);
    send_word(OP_INSERT, KEY_ABCD, 32'h200);
    send_word(OP_SEARCH, KEY_ABCD, '0);
    send_word(OP_DELETE, KEY_ABCD, 32'h100);
    send_word(OP_DELETE, '0, '0);
    send_word(OP_DELETE, '0, '1);
    send_word(OP_SEARCH, KEY_ABCD, '0);

    // fill past capacity, with the output held off for a while
    hold_armed = 1'b1;
    run_traffic(100, 85, 10, 3);
    run_traffic(120, 35, 35, 25);
    run_traffic(50, 10, 20, 68);
    calm = 1'b1;
    run_traffic(40, 10, 20, 68);
    in_tvalid <= 1'b0;

    // the due count of the last word is registered in the checker, so it lags its acceptance
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("sorted_secondary_index: match");
    end else begin
      $display("sorted_secondary_index: mismatch");
    end
    $finish;
  end

  initial begin
    #9_600_000;
    $display("sorted_secondary_index: mismatch");
    $finish;
  end

endmodule
